// File: hw/rtl/seeh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeh_pkg
// shared types and constants of the sensor edge event history block
// ----------------------------------------------------------------------------
package seeh_pkg;

    localparam int SENSORS_PER_BANK = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = 2;

    // operation codes of an input transaction
    localparam logic OP_WORD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // command handed from the front end to the back end
    typedef struct packed {
        logic                        is_read;
        logic [2:0]                  bank;
        logic [SENSORS_PER_BANK-1:0] rose;
        logic [3:0]                  index;
    } t_cmd;

endpackage

// File: hw/rtl/sensor_edge_event_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_edge_event_history
// rising edge detector over sensor banks with a most-recent event history
// ----------------------------------------------------------------------------
// A bank word (operation 0) is compared with the last level of its bank; every
// sensor that rose becomes one result transaction, lowest word bit first
// (sensor position 15 down to 0), and is pushed to the front of the history.
// is_last marks the final event of a word; words without an edge, and words
// for a bank at or above BANK_COUNT, give no result. A read (operation 1)
// gives exactly one result: history entry history_index (0 = most recent) and
// its valid mark, or 0 / invalid for an empty or out-of-range entry. The
// front end takes a transaction whenever the four-entry command queue has
// room; the back end takes a command in its idle state, then emits one edge
// event per cycle while the result channel is not stalled, or for a read
// passes through a read state (history memory has a registered read port)
// and a read output state. The history is a circular buffer with a fill
// count, so reset needs no clearing pass.
module sensor_edge_event_history #(
    parameter int BANK_COUNT    = 5,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [2:0]  i_bank,
    input  logic [15:0] i_bank_word,
    input  logic [3:0]  i_history_index,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_sensor_number,
    output logic        o_entry_valid,
    output logic        o_is_last
);

    logic           accept;
    logic           push;
    seeh_pkg::t_cmd front_cmd;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    seeh_pkg::t_cmd q_cmd;

    // input transaction completes whenever the queue has room
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    // front end: level store and edge detection
    seeh_front #(
        .BANK_COUNT (BANK_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_bank          (i_bank),
        .i_bank_word     (i_bank_word),
        .i_history_index (i_history_index),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // decoupling queue
    seeh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back end: event emission, history buffer, reads
    seeh_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sensor_number (o_sensor_number),
        .o_entry_valid   (o_entry_valid),
        .o_is_last       (o_is_last)
    );

endmodule

// File: hw/rtl/seeh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeh_front
// accepts transactions, keeps sensor levels and finds rising edges
// ----------------------------------------------------------------------------
module seeh_front #(
    parameter int BANK_COUNT = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_operation,
    input  logic [2:0]          i_bank,
    input  logic [15:0]         i_bank_word,
    input  logic [3:0]          i_history_index,
    output logic                o_push,
    output seeh_pkg::t_cmd      o_cmd
);

    localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    logic [15:0] r_levels [BANK_COUNT];
    logic [4:0]  bank_ext;
    logic        bank_ok;
    logic [15:0] prev;
    logic [15:0] rose;

    assign bank_ext = {2'b00, i_bank};
    assign bank_ok  = bank_ext < 5'(BANK_COUNT);
    assign prev     = bank_ok ? r_levels[bank_ext[BW-1:0]] : 16'h0000;
    assign rose     = i_bank_word & ~prev;

    always_comb begin
        o_cmd.is_read = (i_operation == seeh_pkg::OP_READ);
        o_cmd.bank    = i_bank;
        o_cmd.rose    = rose;
        o_cmd.index   = i_history_index;
        // words without an edge or from a missing bank make no command
        o_push = i_accept && ((i_operation == seeh_pkg::OP_READ)
                 || (bank_ok && (rose != 16'h0000)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANK_COUNT; b++) begin
                r_levels[b] <= 16'h0000;
            end
        end else if (i_accept && (i_operation == seeh_pkg::OP_WORD) && bank_ok) begin
            r_levels[bank_ext[BW-1:0]] <= i_bank_word;
        end
    end

endmodule

// File: hw/rtl/seeh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeh_queue
// short command queue between front end and back end
// ----------------------------------------------------------------------------
module seeh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  seeh_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output seeh_pkg::t_cmd o_cmd
);

    seeh_pkg::t_cmd                r_slots [seeh_pkg::QUEUE_DEPTH];
    logic [seeh_pkg::QUEUE_AW-1:0] r_wr;
    logic [seeh_pkg::QUEUE_AW-1:0] r_rd;
    logic [seeh_pkg::QUEUE_AW:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == (seeh_pkg::QUEUE_AW + 1)'(seeh_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slots[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/seeh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeh_back
// emits edge events one per cycle unless the result channel stalls, keeps the history, serves reads
// ----------------------------------------------------------------------------
module seeh_back #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  seeh_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [6:0]     o_sensor_number,
    output logic           o_entry_valid,
    output logic           o_is_last
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = ((AW > 4) ? AW : 4) + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_READ_OUT
    } t_state;

    t_state         r_state;
    seeh_pkg::t_cmd r_cmd;
    logic [AW-1:0]  r_wp;
    logic [CW-1:0]  r_count;
    logic [6:0]     r_hist [HISTORY_DEPTH];
    logic [6:0]     r_rd_data;
    logic           r_rd_hit;
    logic           r_out_valid;
    logic [6:0]     r_out_number;
    logic           r_out_entry;
    logic           r_out_last;

    logic           out_free;
    logic [3:0]     low_bit;
    logic [15:0]    rest;
    logic [6:0]     event_number;
    logic           do_emit;
    logic [SW-1:0]  idx_e;
    logic [SW-1:0]  wp_e;
    logic [SW-1:0]  addr_e;
    logic           hit;

    assign out_free = !r_out_valid || i_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign do_emit  = (r_state == S_SCAN) && out_free;

    // lowest pending edge bit is the next sensor in scan order
    always_comb begin
        low_bit = 4'd0;
        for (int b = seeh_pkg::SENSORS_PER_BANK - 1; b >= 0; b--) begin
            if (r_cmd.rose[b]) begin
                low_bit = 4'(b);
            end
        end
    end

    assign rest         = r_cmd.rose & (r_cmd.rose - 16'd1);
    assign event_number = {r_cmd.bank, ~low_bit};

    // entry i sits i + 1 places behind the write pointer
    always_comb begin
        idx_e = SW'(r_cmd.index);
        wp_e  = SW'(r_wp);
        hit   = idx_e < SW'(r_count);
        if (idx_e < wp_e) begin
            addr_e = wp_e - idx_e - SW'(1);
        end else begin
            addr_e = wp_e + SW'(HISTORY_DEPTH) - idx_e - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_hist[r_wp] <= event_number;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_hist[addr_e[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= i_q_cmd.is_read ? S_READ : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_number <= event_number;
                        r_out_entry  <= 1'b1;
                        r_out_last   <= (rest == 16'h0000);
                        r_cmd.rose   <= rest;
                        r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_count != CW'(HISTORY_DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (rest == 16'h0000) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    r_rd_hit <= hit;
                    r_state  <= S_READ_OUT;
                end
                S_READ_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_number <= r_rd_hit ? r_rd_data : 7'd0;
                        r_out_entry  <= r_rd_hit;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sensor_number = r_out_number;
    assign o_entry_valid   = r_out_entry;
    assign o_is_last       = r_out_last;

endmodule

// File: hw/rtl/seeh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeh_checker
// port level checks of the sensor edge event history block
// ----------------------------------------------------------------------------
module seeh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_sensor_number,
    input logic       o_entry_valid,
    input logic       o_is_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sensor_number)
            && $stable(o_entry_valid) && $stable(o_is_last))
        else $error("stalled result changed");

    // an invalid entry only comes from a read, which is always last
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_is_last)
        else $error("invalid entry not marked last");

    // an invalid entry reads as zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_sensor_number == 7'd0)
        else $error("invalid entry carries a number");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

endmodule

bind sensor_edge_event_history seeh_checker u_seeh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_sensor_number (o_sensor_number),
    .o_entry_valid   (o_entry_valid),
    .o_is_last       (o_is_last)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the sensor edge event history block: a directed table of
// corner cases, then random bank words and history reads with random gaps on
// both channels, every result checked in order against its table row or a local model
// ----------------------------------------------------------------------------
module tb_top;

    localparam int BANK_COUNT     = 5;
    localparam int HISTORY_DEPTH  = 16;
    localparam int RANDOM_ITEMS   = 387;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DIRECTED_ROWS  = 23;

    // one result transaction as the block should present it
    typedef struct packed {
        logic [6:0] number;
        logic       filled;
        logic       last;
    } t_sensor_event;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic        op;
        logic [2:0]  bank;
        logic [15:0] word;
        logic [3:0]  index;
        logic        typed;
        logic        typed_has_result;
        logic [6:0]  typed_number;
        logic        typed_filled;
    } t_stim_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        i_operation     = seeh_pkg::OP_WORD;
    logic [2:0]  i_bank          = 3'd0;
    logic [15:0] i_bank_word     = 16'h0000;
    logic [3:0]  i_history_index = 4'd0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [6:0]  o_sensor_number;
    logic        o_entry_valid;
    logic        o_is_last;

    // local model of the block: sensor levels per bank and the event history
    logic [15:0] bank_levels [BANK_COUNT];
    logic [6:0]  hist_number [HISTORY_DEPTH];
    logic        hist_filled [HISTORY_DEPTH];

    // results still owed by the block, oldest first
    t_sensor_event pending_events[$];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  rx_hold     = 0;
    bit  calm        = 1'b0;

    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        // reads of an empty history right after reset
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd0,  1'b1, 1'b1, 7'd0,  1'b0},
        '{seeh_pkg::OP_READ, 3'd7, 16'hffff, 4'd15, 1'b1, 1'b1, 7'd0,  1'b0},
        // lowest and highest sensor numbers
        '{seeh_pkg::OP_WORD, 3'd0, 16'h8000, 4'd0,  1'b1, 1'b1, 7'd0,  1'b1},
        '{seeh_pkg::OP_WORD, 3'd4, 16'h0001, 4'd15, 1'b1, 1'b1, 7'd79, 1'b1},
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd0,  1'b1, 1'b1, 7'd79, 1'b1},
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd1,  1'b1, 1'b1, 7'd0,  1'b1},
        // entry never filled
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd2,  1'b1, 1'b1, 7'd0,  1'b0},
        // level held high: no edge
        '{seeh_pkg::OP_WORD, 3'd0, 16'h8000, 4'd0,  1'b1, 1'b0, 7'd0,  1'b0},
        // banks out of range are ignored
        '{seeh_pkg::OP_WORD, 3'd5, 16'hffff, 4'd0,  1'b1, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd7, 16'hffff, 4'd0,  1'b1, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd6, 16'h1234, 4'd0,  1'b1, 1'b0, 7'd0,  1'b0},
        // falling edge only
        '{seeh_pkg::OP_WORD, 3'd0, 16'h0000, 4'd0,  1'b1, 1'b0, 7'd0,  1'b0},
        // full banks: sixteen events each, history wraps
        '{seeh_pkg::OP_WORD, 3'd0, 16'hffff, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd1, 16'hffff, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd15, 1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd2, 16'haaaa, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd2, 16'h5555, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd3, 16'h0180, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd4, 16'hffff, 4'd0,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_READ, 3'd0, 16'h0000, 4'd7,  1'b0, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_WORD, 3'd4, 16'h0000, 4'd0,  1'b1, 1'b0, 7'd0,  1'b0},
        '{seeh_pkg::OP_READ, 3'd5, 16'hc3c3, 4'd8,  1'b0, 1'b0, 7'd0,  1'b0}
    };

    sensor_edge_event_history #(
        .BANK_COUNT    (BANK_COUNT),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_bank          (i_bank),
        .i_bank_word     (i_bank_word),
        .i_history_index (i_history_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sensor_number (o_sensor_number),
        .o_entry_valid   (o_entry_valid),
        .o_is_last       (o_is_last)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long; none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // advance the local model by one accepted transaction; when commit is set
    // the results it owes are queued for checking
    task automatic predict_history(input logic op, input logic [2:0] bank,
                                   input logic [15:0] word, input logic [3:0] index,
                                   input bit commit);
        t_sensor_event ev;
        logic [15:0]   rose;
        int            rose_total;
        int            rose_seen;
        int            id;
        if (op == seeh_pkg::OP_READ) begin
            ev.number = 7'd0;
            ev.filled = 1'b0;
            ev.last   = 1'b1;
            if (int'(index) < HISTORY_DEPTH && hist_filled[index]) begin
                ev.number = hist_number[index];
                ev.filled = 1'b1;
            end
            if (commit)
                pending_events.push_back(ev);
        end else if (int'(bank) < BANK_COUNT) begin
            rose              = word & ~bank_levels[bank];
            bank_levels[bank] = word;
            rose_total        = $countones(rose);
            rose_seen         = 0;
            // bit 0 is sensor position 15, so the scan runs up the word
            for (int b = 0; b < seeh_pkg::SENSORS_PER_BANK; b++) begin
                if (rose[b]) begin
                    rose_seen++;
                    id        = int'(bank) * seeh_pkg::SENSORS_PER_BANK
                                + seeh_pkg::SENSORS_PER_BANK - 1 - b;
                    ev.number = id[6:0];
                    ev.filled = 1'b1;
                    ev.last   = (rose_seen == rose_total);
                    for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                        hist_number[k] = hist_number[k-1];
                        hist_filled[k] = hist_filled[k-1];
                    end
                    hist_number[0] = ev.number;
                    hist_filled[0] = 1'b1;
                    if (commit)
                        pending_events.push_back(ev);
                end
            end
        end
    endtask

    // present one transaction, hold it until accepted, then update the model;
    // valid stays high on return so a back-to-back transaction needs no gap
    task automatic send_item(input logic op, input logic [2:0] bank,
                             input logic [15:0] word, input logic [3:0] index,
                             input bit commit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_bank          <= bank;
        i_bank_word     <= word;
        i_history_index <= index;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_history(op, bank, word, index, commit);
    endtask

    // sender holds off until the block owes nothing
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // result side backpressure
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rx_hold <= pick_gap();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_sensor_event ev;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                flag_error($sformatf("result with nothing expected: sensor %0d valid %0b last %0b",
                                     o_sensor_number, o_entry_valid, o_is_last));
            end else begin
                ev = pending_events.pop_front();
                if (o_sensor_number !== ev.number)
                    flag_error($sformatf("sensor_number %0d, expected %0d",
                                         o_sensor_number, ev.number));
                if (o_entry_valid !== ev.filled)
                    flag_error($sformatf("entry_valid %0b, expected %0b (sensor %0d)",
                                         o_entry_valid, ev.filled, ev.number));
                if (o_is_last !== ev.last)
                    flag_error($sformatf("is_last %0b, expected %0b (sensor %0d)",
                                         o_is_last, ev.last, ev.number));
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_stim_row     row;
        t_sensor_event ev;
        int            sent;
        int            pick;
        int            mode;
        logic          op;
        logic [2:0]    bank;
        logic [15:0]   word;
        logic [3:0]    index;

        for (int b = 0; b < BANK_COUNT; b++)
            bank_levels[b] = 16'h0000;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_number[k] = 7'd0;
            hist_filled[k] = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; typed rows queue their own expectation while the
        // model still tracks the state they change
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            send_item(row.op, row.bank, row.word, row.index, !row.typed);
            if (row.typed && row.typed_has_result) begin
                ev.number = row.typed_number;
                ev.filled = row.typed_filled;
                ev.last   = 1'b1;
                pending_events.push_back(ev);
            end
        end

        // random part: mostly bank words shaped to make edges, some reads,
        // and a few words for banks that do not exist
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent % 100) >= 75;
            if (sent == RANDOM_ITEMS / 2)
                wait_for_results();
            pick  = $urandom_range(0, 99);
            index = 4'($urandom_range(0, 15));
            word  = 16'($urandom);
            if (pick < 28) begin
                op   = seeh_pkg::OP_READ;
                bank = 3'($urandom_range(0, 7));
                sent++;
            end else if (pick < 34) begin
                op   = seeh_pkg::OP_WORD;
                bank = 3'($urandom_range(BANK_COUNT, 7));
                sent++;
            end else begin
                op   = seeh_pkg::OP_WORD;
                bank = 3'($urandom_range(0, BANK_COUNT - 1));
                mode = $urandom_range(0, 9);
                case (mode)
                    4, 5, 6: begin
                        // toggle one or two sensors
                        word = bank_levels[bank] ^ (16'h1 << $urandom_range(0, 15))
                               ^ (16'($urandom_range(0, 1)) << $urandom_range(0, 15));
                    end
                    7: word = 16'h0000;
                    8: word = 16'hffff;
                    9: word = bank_levels[bank] | 16'($urandom);
                    default: ;
                endcase
                sent++;
            end
            send_item(op, bank, word, index, 1'b1);
        end

        calm = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_events.size() == 0) begin
            $display("status: pass");
        end else begin
            if (pending_events.size() != 0)
                flag_error($sformatf("%0d results never arrived", pending_events.size()));
            $display("status: fail");
        end
        $finish;
    end

endmodule
